/* rtl/sha256mh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_pkg
// Shared widths, hash constants, command and status types and the SHA-256
// round functions for the message hasher.
// ----------------------------------------------------------------------------
package sha256mh_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 3;
   localparam int COUNT_W = 61;
   localparam int POS_W   = 6;
   localparam int ROUND_W = 6;
   localparam int BLOCK_WORDS  = 16;
   localparam int DIGEST_WORDS = 8;

   localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;
   localparam logic [POS_W-1:0]   LAST_POS   = 6'd63;
   localparam logic [POS_W-1:0]   LENGTH_POS = 6'd56;
   localparam logic [ROUND_W-1:0] LAST_ROUND = 6'd63;
   localparam logic [INDEX_W-1:0] LAST_INDEX = 3'd7;

   localparam logic [WORD_W-1:0] INIT_HASH [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // controller to datapath
   typedef struct packed {
      logic               absorb;   // write message byte, bump count
      logic               pad;      // write 0x80 at current position
      logic               length;   // write bit length into last two words
      logic               init;     // load schedule and working variables
      logic               round;    // one compression round
      logic               fold;     // add into chaining value, clear buffer
      logic               restart;  // back to initial hash, count cleared
      logic [ROUND_W-1:0] round_idx;
      logic [INDEX_W-1:0] word_idx;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [POS_W-1:0] pos;        // byte position within the block
   } status_type;

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

/* rtl/sha256mh_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_req_if
// Request channel: at most one message byte per transaction, with end mark.
// ----------------------------------------------------------------------------
interface sha256mh_req_if;
   logic                              valid;
   logic                              ready;
   logic [sha256mh_pkg::BYTE_W-1:0]   msg_byte;
   logic                              byte_present;
   logic                              end_of_message;

   modport source (output valid, output msg_byte, output byte_present,
                   output end_of_message, input ready);
   modport sink   (input valid, input msg_byte, input byte_present,
                   input end_of_message, output ready);
endinterface

/* rtl/sha256mh_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_rsp_if
// Response channel: one digest word per transaction.
// ----------------------------------------------------------------------------
interface sha256mh_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sha256mh_pkg::WORD_W-1:0]   digest_word;
   logic [sha256mh_pkg::INDEX_W-1:0]  word_index;
   logic                              last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

/* rtl/sha256mh_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_dp
// Datapath: block buffer, byte count, chaining value, schedule window and
// working variables with the one-round compression logic.
// ----------------------------------------------------------------------------
module sha256mh_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  sha256mh_pkg::cmd_type            cmd,
   input  logic [sha256mh_pkg::BYTE_W-1:0]  msg_byte,
   output sha256mh_pkg::status_type         status,
   output logic [sha256mh_pkg::WORD_W-1:0]  digest_word
);

   logic [sha256mh_pkg::WORD_W-1:0]  chain_ff  [sha256mh_pkg::DIGEST_WORDS];
   logic [sha256mh_pkg::WORD_W-1:0]  chain_in  [sha256mh_pkg::DIGEST_WORDS];
   logic [sha256mh_pkg::WORD_W-1:0]  buffer_ff [sha256mh_pkg::BLOCK_WORDS];
   logic [sha256mh_pkg::WORD_W-1:0]  buffer_in [sha256mh_pkg::BLOCK_WORDS];
   logic [sha256mh_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [sha256mh_pkg::WORD_W-1:0]  work_ff   [sha256mh_pkg::DIGEST_WORDS];
   logic [sha256mh_pkg::WORD_W-1:0]  work_in   [sha256mh_pkg::DIGEST_WORDS];
   logic [sha256mh_pkg::WORD_W-1:0]  window_ff [sha256mh_pkg::BLOCK_WORDS];
   logic [sha256mh_pkg::WORD_W-1:0]  window_in [sha256mh_pkg::BLOCK_WORDS];

   logic [sha256mh_pkg::POS_W-1:0]   pos;
   logic [sha256mh_pkg::BYTE_W-1:0]  lane_byte;
   logic [sha256mh_pkg::WORD_W-1:0]  lane_word;
   logic [63:0]                      bit_len;
   logic [sha256mh_pkg::WORD_W-1:0]  w_next, t1, t2;

   assign pos        = count_ff[sha256mh_pkg::POS_W-1:0];
   assign status.pos = pos;
   assign digest_word = chain_ff[cmd.word_idx];

   // big-endian byte lane within the word
   assign lane_byte = cmd.absorb ? msg_byte : sha256mh_pkg::PAD_BYTE;
   assign lane_word = {24'b0, lane_byte} << {~pos[1:0], 3'b000};
   assign bit_len   = {count_ff, 3'b000};

   // W[r+16] from the window holding W[r..r+15]
   assign w_next = sha256mh_pkg::small_sigma1(window_ff[14]) + window_ff[9] +
                   sha256mh_pkg::small_sigma0(window_ff[1]) + window_ff[0];

   assign t1 = work_ff[7] + sha256mh_pkg::big_sigma1(work_ff[4]) +
               ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6])) +
               sha256mh_pkg::ROUND_K[cmd.round_idx] + window_ff[0];
   assign t2 = sha256mh_pkg::big_sigma0(work_ff[0]) +
               ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                (work_ff[1] & work_ff[2]));

   always_comb begin
      buffer_in = buffer_ff;
      chain_in  = chain_ff;
      count_in  = count_ff;
      work_in   = work_ff;
      window_in = window_ff;
      if (cmd.absorb || cmd.pad) begin
         buffer_in[pos[5:2]] = buffer_ff[pos[5:2]] | lane_word;
      end
      if (cmd.absorb) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.length) begin
         buffer_in[14] = bit_len[63:32];
         buffer_in[15] = bit_len[31:0];
      end
      if (cmd.init) begin
         window_in = buffer_ff;
         work_in   = chain_ff;
      end
      if (cmd.round) begin
         for (int i = 0; i < sha256mh_pkg::BLOCK_WORDS - 1; i++) begin
            window_in[i] = window_ff[i+1];
         end
         window_in[15] = w_next;
         for (int i = 1; i < sha256mh_pkg::DIGEST_WORDS; i++) begin
            work_in[i] = work_ff[i-1];
         end
         work_in[4] = work_ff[3] + t1;
         work_in[0] = t1 + t2;
      end
      if (cmd.fold) begin
         for (int i = 0; i < sha256mh_pkg::DIGEST_WORDS; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.fold || cmd.restart) begin
         for (int i = 0; i < sha256mh_pkg::BLOCK_WORDS; i++) begin
            buffer_in[i] = '0;
         end
      end
      if (cmd.restart) begin
         chain_in = sha256mh_pkg::INIT_HASH;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha256mh_pkg::INIT_HASH;
         count_ff <= '0;
         for (int i = 0; i < sha256mh_pkg::BLOCK_WORDS; i++) begin
            buffer_ff[i] <= '0;
         end
      end else begin
         chain_ff  <= chain_in;
         count_ff  <= count_in;
         buffer_ff <= buffer_in;
      end
   end

   // no reset: always written by init before any read
   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      window_ff <= window_in;
   end

endmodule

/* rtl/sha256mh_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256mh_ctrl
// Controller: sequences byte intake, padding, compression rounds and
// digest readout, and drives the datapath commands.
// ----------------------------------------------------------------------------
module sha256mh_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_byte_present,
   input  logic                       req_end_of_message,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  sha256mh_pkg::status_type   status,
   output sha256mh_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_PAD, S_LENGTH, S_INIT, S_ROUND, S_FOLD, S_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      RET_BYTE, RET_PAD, RET_FINAL
   } return_type;

   state_type                         state_ff, state_in;
   return_type                        ret_ff, ret_in;
   logic                              end_ff, end_in;
   logic [sha256mh_pkg::ROUND_W-1:0]  round_ff, round_in;
   logic [sha256mh_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic                              req_take;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUTPUT);
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      end_in   = end_ff;
      round_in = round_ff;
      index_in = index_ff;
      cmd           = '0;
      cmd.round_idx = round_ff;
      cmd.word_idx  = index_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               end_in = req_end_of_message;
               if (req_byte_present) begin
                  cmd.absorb = 1'b1;
                  if (status.pos == sha256mh_pkg::LAST_POS) begin
                     ret_in   = RET_BYTE;
                     state_in = S_INIT;
                  end else if (req_end_of_message) begin
                     state_in = S_PAD;
                  end
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.pad = 1'b1;
            if (status.pos >= sha256mh_pkg::LENGTH_POS) begin
               ret_in   = RET_PAD;
               state_in = S_INIT;
            end else begin
               state_in = S_LENGTH;
            end
         end
         S_LENGTH: begin
            cmd.length = 1'b1;
            ret_in     = RET_FINAL;
            state_in   = S_INIT;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            round_in  = round_ff + 1'b1;
            if (round_ff == sha256mh_pkg::LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.fold = 1'b1;
            case (ret_ff)
               RET_BYTE:  state_in = end_ff ? S_PAD : S_IDLE;
               RET_PAD:   state_in = S_LENGTH;
               RET_FINAL: begin
                  index_in = '0;
                  state_in = S_OUTPUT;
               end
               default:   state_in = S_IDLE;
            endcase
         end
         S_OUTPUT: begin
            if (rsp_ready) begin
               index_in = index_ff + 1'b1;
               if (index_ff == sha256mh_pkg::LAST_INDEX) begin
                  cmd.restart = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_BYTE;
         end_ff   <= 1'b0;
         round_ff <= '0;
         index_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         end_ff   <= end_in;
         round_ff <= round_in;
         index_ff <= index_in;
      end
   end

   // intake and readout never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request ready while digest is pending");

   // after the last digest word the block takes requests again
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && cmd.word_idx == sha256mh_pkg::LAST_INDEX)
      |=> req_ready)
      else $error("not idle after final digest word");

   // round counter rests at zero outside the round loop
   a_round_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ROUND) |-> (round_ff == '0))
      else $error("round counter not at zero outside rounds");

   // readout always starts with word zero
   a_first_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (cmd.word_idx == '0))
      else $error("digest readout did not start at word zero");

endmodule

/* rtl/sha256_message_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream: packs bytes big-endian into 64-byte blocks,
// compresses each block, pads on end of message and returns the digest as
// eight 32-bit words.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                 per transaction
//  --------  ---------  --------------------------------------  ------------------
//  req_bus   in         msg_byte, byte_present, end_of_message  one byte or end
//  rsp_bus   out        digest_word, word_index, last_word      one digest word
//
//  A byte that does not fill a block is only absorbed. A byte that
//  completes a block adds a compression: a load, 64 rounds and a fold, done by the
//  single shared round unit doing one round per cycle.
//  End of message: a padding step and a length step, one compression or
//  two, then eight digest transactions.
//  Reset: synchronous; chaining value back to the initial hash.
//  Stalls: req_bus.ready is high only while idle; rsp_bus.ready low holds the
//  current digest word until taken.
//
module sha256_message_hasher (
   input  logic          clock,
   input  logic          reset,
   sha256mh_req_if.sink   req_bus,
   sha256mh_rsp_if.source rsp_bus
);

   sha256mh_pkg::cmd_type    cmd;     // controller commands to the datapath
   sha256mh_pkg::status_type status;  // byte position back to the controller

   // sequencer: intake, padding, rounds, digest readout
   sha256mh_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_bus.valid),
      .req_byte_present   (req_bus.byte_present),
      .req_end_of_message (req_bus.end_of_message),
      .req_ready          (req_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .status             (status),
      .cmd                (cmd)
   );

   // block buffer, counters, schedule and round logic
   sha256mh_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .msg_byte    (req_bus.msg_byte),
      .status      (status),
      .digest_word (rsp_bus.digest_word)
   );

   // word index follows the readout counter, most significant word first
   assign rsp_bus.word_index = cmd.word_idx;
   assign rsp_bus.last_word  = (cmd.word_idx == sha256mh_pkg::LAST_INDEX);

endmodule
